// ===== rtl/core/md4_pkg.sv =====
package md4_pkg;

  localparam int WORD_W     = 32;
  localparam int BLK_WORDS  = 16;
  localparam int STEPS      = 48;
  localparam int DEF_SLOTS  = 2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K2  = 32'h5A827999;
  localparam logic [31:0] K3  = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [4:0] R1_SH [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
  localparam logic [4:0] R2_SH [4] = '{5'd3, 5'd5, 5'd9, 5'd13};
  localparam logic [4:0] R3_SH [4] = '{5'd3, 5'd9, 5'd11, 5'd15};

  localparam logic [1:0] RND_1 = 2'd0;
  localparam logic [1:0] RND_2 = 2'd1;

  // front to queue: word write and block hand-over
  typedef struct packed {
    logic        we;
    logic [3:0]  widx;
    logic [31:0] wdata;
    logic        push;
    logic        last_blk;
  } fwr_t;

  // queue to back
  typedef struct packed {
    logic avail;
    logic last_blk;
  } qstat_t;

  // back to queue
  typedef struct packed {
    logic       re;
    logic [3:0] ridx;
    logic       pop;
  } brd_t;

  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] j;
    j = step[3:0];
    case (step[5:4])
      RND_1:   msg_index = j;
      RND_2:   msg_index = {j[1:0], j[3:2]};
      default: msg_index = {j[0], j[1], j[2], j[3]};
    endcase
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] step);
    case (step[5:4])
      RND_1:   shift_amt = R1_SH[step[1:0]];
      RND_2:   shift_amt = R2_SH[step[1:0]];
      default: shift_amt = R3_SH[step[1:0]];
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    rotl32 = t[63:32];
  endfunction

endpackage

// ===== rtl/core/md4_if.sv =====
interface md4_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       is_last;

  modport source (output valid, data_byte, byte_valid, is_last, input ready);
  modport sink (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface md4_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_lo;
  logic [63:0] digest_hi;

  modport source (output valid, digest_lo, digest_hi, input ready);
  modport sink (input valid, digest_lo, digest_hi, output ready);
endinterface

// ===== rtl/core/md4_digest_engine.sv =====
// md4 digest engine
// msg: one message word (byte) per handshake, byte_valid marks a real byte and
//   is_last closes the message; a word with byte_valid low and is_last high
//   ends the message with what has been gathered (an empty message if nothing).
// dig: one word per message, the 128-bit digest as digest_lo (bytes 0..7) and
//   digest_hi (bytes 8..15).
// throughput: one byte per cycle while slots are free and no padding runs;
//   each 64-byte block passes the compression unit as load, 48 steps and chain
//   add, one step per cycle through a single rotator.
// after the last word, padding writes one word per cycle while a slot is free
//   (up to 16, or 18 when the length spills into an extra block), then each
//   queued block goes through compression; the digest shows in the output
//   register in the cycle after the final chain add.
// NumSlots sets how many 64-byte blocks the queue buffers between gathering
//   and compression; msg.ready drops while all slots are taken or padding runs.
// reset: chaining words return to the md4 initial values, the queue empties
//   and no digest is pending; block storage is not cleared.
// a stalled digest holds in the output register; the compression unit then
//   waits at a last block's final add and the front stalls once slots are full.
module md4_digest_engine #(
  parameter int NumSlots = md4_pkg::DEF_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  md4_msg_if.sink   msg,
  md4_dig_if.source dig
);

  md4_pkg::fwr_t   wr;
  md4_pkg::brd_t   rd;
  md4_pkg::qstat_t qs;
  logic            space;
  logic [31:0]     rdata;

  md4_front u_front (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg),
    .space(space),
    .wr   (wr)
  );

  md4_blkq #(
    .NumSlots(NumSlots)
  ) u_blkq (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .space(space),
    .rd   (rd),
    .qs   (qs),
    .rdata(rdata)
  );

  md4_back u_back (
    .clk  (clk),
    .rst  (rst),
    .qs   (qs),
    .rdata(rdata),
    .rd   (rd),
    .dig  (dig)
  );

endmodule

// ===== rtl/core/md4_ram.sv =====
module md4_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/md4_front.sv =====
module md4_front (
  input  logic          clk,
  input  logic          rst,
  md4_msg_if.sink       msg,
  input  logic          space,
  output md4_pkg::fwr_t wr
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_PAD  = 1'b1;

  logic        state;
  logic [5:0]  fill;
  logic [31:0] acc;
  logic [63:0] bit_len;
  logic        mark_done;
  logic        len_ok;

  logic        accept;
  logic [1:0]  p;
  logic [3:0]  w;
  logic [31:0] acc_upd;
  logic [31:0] pad_word;
  logic        pad_go;
  logic        pad_end;

  assign p         = fill[1:0];
  assign w         = fill[5:2];
  assign msg.ready = (state == F_IDLE) && space;
  assign accept    = msg.valid && msg.ready;
  assign pad_go    = (state == F_PAD) && space;
  assign pad_end   = pad_go && mark_done && len_ok && (w == 4'd15);

  always_comb begin
    acc_upd = acc;
    case (p)
      2'd0:    acc_upd[7:0]   = msg.data_byte;
      2'd1:    acc_upd[15:8]  = msg.data_byte;
      2'd2:    acc_upd[23:16] = msg.data_byte;
      default: acc_upd[31:24] = msg.data_byte;
    endcase
  end

  // partial word: bytes below fill, marker, zeros; later zeros or length
  always_comb begin
    pad_word = '0;
    if (mark_done) begin
      if (len_ok && w == 4'd14) begin
        pad_word = bit_len[31:0];
      end else if (len_ok && w == 4'd15) begin
        pad_word = bit_len[63:32];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (2'(k) < p) begin
          pad_word[8*k +: 8] = acc[8*k +: 8];
        end else if (2'(k) == p) begin
          pad_word[8*k +: 8] = md4_pkg::PAD_BYTE;
        end
      end
    end
  end

  always_comb begin
    wr = '0;
    unique case (state)
      F_IDLE: begin
        if (accept && msg.byte_valid && p == 2'd3) begin
          wr.we    = 1'b1;
          wr.widx  = w;
          wr.wdata = acc_upd;
          wr.push  = (w == 4'd15);
        end
      end
      F_PAD: begin
        if (pad_go) begin
          wr.we       = 1'b1;
          wr.widx     = w;
          wr.wdata    = pad_word;
          wr.push     = (w == 4'd15);
          wr.last_blk = pad_end;
        end
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      mark_done <= 1'b0;
      len_ok    <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (msg.byte_valid) begin
              acc     <= acc_upd;
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
            if (msg.is_last) begin
              state     <= F_PAD;
              mark_done <= 1'b0;
              len_ok    <= 1'b0;
            end
          end
        end
        F_PAD: begin
          if (pad_go) begin
            // wraps to zero after word 15
            fill <= {w + 4'd1, 2'b00};
            if (!mark_done) begin
              mark_done <= 1'b1;
              // marker in word 14 leaves no room for the length
              len_ok    <= (w != 4'd14);
            end else if (pad_end) begin
              state   <= F_IDLE;
              bit_len <= '0;
            end else if (w == 4'd15) begin
              len_ok <= 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/md4_blkq.sv =====
module md4_blkq #(
  parameter int NumSlots = md4_pkg::DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  md4_pkg::fwr_t    wr,
  output logic             space,
  input  md4_pkg::brd_t    rd,
  output md4_pkg::qstat_t  qs,
  output logic [31:0]      rdata
);

  localparam int SlotW = $clog2(NumSlots);
  localparam int CntW  = $clog2(NumSlots + 1);
  localparam int AddrW = SlotW + 4;
  localparam int Depth = NumSlots * md4_pkg::BLK_WORDS;

  logic [SlotW-1:0] wr_ptr;
  logic [SlotW-1:0] rd_ptr;
  logic [CntW-1:0]  count;
  logic             fin [NumSlots];

  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign space       = (count < CntW'(NumSlots));
  assign qs.avail    = (count != '0);
  assign qs.last_blk = fin[rd_ptr];
  assign waddr       = {wr_ptr, wr.widx};
  assign raddr       = {rd_ptr, rd.ridx};

  md4_ram #(
    .Width(md4_pkg::WORD_W),
    .Depth(Depth)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(waddr),
    .wdata(wr.wdata),
    .re   (rd.re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        fin[wr_ptr] <= wr.last_blk;
        wr_ptr      <= (wr_ptr == SlotW'(NumSlots - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd.pop) begin
        rd_ptr <= (rd_ptr == SlotW'(NumSlots - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !rd.pop) begin
        count <= count + 1'b1;
      end else if (!wr.push && rd.pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/md4_back.sv =====
module md4_back (
  input  logic            clk,
  input  logic            rst,
  input  md4_pkg::qstat_t qs,
  input  logic [31:0]     rdata,
  output md4_pkg::brd_t   rd,
  md4_dig_if.source       dig
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;

  localparam logic [5:0] LAST_STEP = 6'(md4_pkg::STEPS - 1);

  logic [1:0]  state;
  logic [5:0]  step;
  logic [31:0] a, b, c, d;
  logic [31:0] h0, h1, h2, h3;
  logic        out_valid;
  logic [63:0] dlo, dhi;

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] newv;
  logic [31:0] s0, s1, s2, s3;
  logic        can_out;

  assign dig.valid     = out_valid;
  assign dig.digest_lo = dlo;
  assign dig.digest_hi = dhi;
  assign can_out       = !out_valid || dig.ready;

  always_comb begin
    case (step[5:4])
      md4_pkg::RND_1: f = (b & c) | (~b & d);
      md4_pkg::RND_2: f = ((b & c) | (b & d) | (c & d)) + md4_pkg::K2;
      default:        f = (b ^ c ^ d) + md4_pkg::K3;
    endcase
  end

  assign sum  = a + f + rdata;
  assign newv = md4_pkg::rotl32(sum, md4_pkg::shift_amt(step));
  assign s0   = h0 + a;
  assign s1   = h1 + b;
  assign s2   = h2 + c;
  assign s3   = h3 + d;

  always_comb begin
    rd = '0;
    unique case (state)
      B_IDLE: begin
        rd.re   = qs.avail;
        rd.ridx = md4_pkg::msg_index(6'd0);
      end
      B_RUN: begin
        rd.re   = (step != LAST_STEP);
        rd.ridx = md4_pkg::msg_index(step + 6'd1);
      end
      B_ADD: begin
        rd.pop = !qs.last_blk || can_out;
      end
      default: rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      h0        <= md4_pkg::IV0;
      h1        <= md4_pkg::IV1;
      h2        <= md4_pkg::IV2;
      h3        <= md4_pkg::IV3;
      out_valid <= 1'b0;
    end else begin
      if (state == B_ADD && rd.pop && qs.last_blk) begin
        out_valid <= 1'b1;
      end else if (dig.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (qs.avail) begin
            a     <= h0;
            b     <= h1;
            c     <= h2;
            d     <= h3;
            step  <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          // roles rotate so the updated word always sits in b
          a <= d;
          b <= newv;
          c <= b;
          d <= c;
          if (step == LAST_STEP) begin
            state <= B_ADD;
          end else begin
            step <= step + 6'd1;
          end
        end
        B_ADD: begin
          if (rd.pop) begin
            state <= B_IDLE;
            if (qs.last_blk) begin
              dlo <= {s1, s0};
              dhi <= {s3, s2};
              h0  <= md4_pkg::IV0;
              h1  <= md4_pkg::IV1;
              h2  <= md4_pkg::IV2;
              h3  <= md4_pkg::IV3;
            end else begin
              h0 <= s0;
              h1 <= s1;
              h2 <= s2;
              h3 <= s3;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/md4_chk.sv =====
module md4_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_last,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [63:0] dig_lo,
  input logic [63:0] dig_hi
);

  // nothing pending comes out of reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !dig_valid)
    else $error("digest valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_lo) && $stable(dig_hi))
    else $error("stalled digest changed");

  // padding follows a closing word, so the front cannot take another at once
  a_pad_stall: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_ready && msg_last |=> !msg_ready)
    else $error("word taken during padding");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> !$past(msg_valid && msg_ready && msg_last))
    else $error("digest right after closing word");

endmodule

bind md4_digest_engine md4_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .msg_valid(msg.valid),
  .msg_ready(msg.ready),
  .msg_last (msg.is_last),
  .dig_valid(dig.valid),
  .dig_ready(dig.ready),
  .dig_lo   (dig.digest_lo),
  .dig_hi   (dig.digest_hi)
);

// ===== test/tb_md4_digest_engine.sv =====
module tb_md4_digest_engine;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 900;
  localparam int END_CYCLES = 200;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] ROUND2_ADD = 32'h5A827999;
  localparam logic [31:0] ROUND3_ADD = 32'h6ED9EBA1;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam int ROT1 [4] = '{3, 7, 11, 19};
  localparam int ROT2 [4] = '{3, 5, 9, 13};
  localparam int ROT3 [4] = '{3, 9, 11, 15};
  localparam int ORDER3 [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};

  typedef struct {
    logic [7:0] data;
    logic       bval;
    logic       last;
    bit         drain;
  } msg_word_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  logic clk;
  logic rst;

  md4_msg_if msg ();
  md4_dig_if dig ();

  md4_digest_engine u_top (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .dig(dig)
  );

  msg_word_t stim_q [$];
  digest_t   digest_q [$];
  logic [7:0] msg_bytes [$];

  // predictor state
  logic [31:0] blk [16];
  logic [31:0] chain [4];
  logic [63:0] bit_len;
  logic [5:0]  fill;

  msg_word_t cur;
  digest_t   got_want;
  int        errors;
  int        words_taken;
  int        digests_checked;
  int        msgs_queued;
  int        live_words;
  int        cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit calm();
    return words_taken >= 300 && words_taken < 450;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void md4_compress();
    logic [31:0] w [4];
    logic [31:0] b, c, d, f, x;
    int t, j, s;
    for (int k = 0; k < 4; k++) w[k] = chain[k];
    for (int i = 0; i < 48; i++) begin
      t = (4 - (i % 4)) % 4;
      b = w[(t + 1) % 4];
      c = w[(t + 2) % 4];
      d = w[(t + 3) % 4];
      j = i % 16;
      if (i < 16) begin
        f = (b & c) | (~b & d);
        x = blk[j];
        s = ROT1[i % 4];
      end else if (i < 32) begin
        f = ((b & c) | (b & d) | (c & d)) + ROUND2_ADD;
        x = blk[(j % 4) * 4 + j / 4];
        s = ROT2[i % 4];
      end else begin
        f = (b ^ c ^ d) + ROUND3_ADD;
        x = blk[ORDER3[j]];
        s = ROT3[i % 4];
      end
      w[t] = rol(w[t] + f + x, s);
    end
    for (int k = 0; k < 4; k++) chain[k] = chain[k] + w[k];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk[fill[5:2]][fill[1:0] * 8 +: 8] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) md4_compress();
  endfunction

  function automatic void start_message();
    chain[0] = INIT_A;
    chain[1] = INIT_B;
    chain[2] = INIT_C;
    chain[3] = INIT_D;
    bit_len = '0;
    fill = '0;
  endfunction

  // one accepted word through the predictor
  function automatic void apply_word(input msg_word_t w);
    logic [63:0] len;
    digest_t dg;
    if (w.bval) begin
      absorb_byte(w.data);
      bit_len = bit_len + 64'd8;
    end
    if (w.last) begin
      len = bit_len;
      absorb_byte(PAD_MARK);
      while (fill != 6'd56) absorb_byte(8'h00);
      blk[14] = len[31:0];
      blk[15] = len[63:32];
      md4_compress();
      dg.lo = {chain[1], chain[0]};
      dg.hi = {chain[3], chain[2]};
      digest_q.push_back(dg);
      start_message();
    end
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic bval,
                                    input logic last, input bit drain);
    msg_word_t w;
    w.data = data;
    w.bval = bval;
    w.last = last;
    w.drain = drain;
    stim_q.push_back(w);
    if (bval || last) live_words++;
  endfunction

  // queues msg_bytes as one message; close_empty ends it with a word carrying no byte
  function automatic void queue_message(input bit close_empty, input bit drain,
                                        input bit noise);
    int n;
    n = msg_bytes.size();
    if (n == 0) close_empty = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (noise && $urandom_range(9) == 0) push_word(8'($urandom), 1'b0, 1'b0, 1'b0);
      push_word(msg_bytes[k], 1'b1, (k == n - 1) && !close_empty, drain && k == 0);
    end
    if (close_empty) push_word(8'($urandom), 1'b0, 1'b1, drain && n == 0);
    msgs_queued++;
    msg_bytes.delete();
  endfunction

  function automatic void build_stimulus();
    int len, pick;
    int odd_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    // directed: idle word, empty message, byte extremes, short text, late close
    push_word(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_message(1'b1, 1'b0, 1'b0);
    msg_bytes.push_back(8'h00);
    queue_message(1'b0, 1'b0, 1'b0);
    msg_bytes.push_back(8'hFF);
    queue_message(1'b0, 1'b0, 1'b0);
    msg_bytes.push_back(8'h61);
    msg_bytes.push_back(8'h62);
    msg_bytes.push_back(8'h63);
    queue_message(1'b0, 1'b1, 1'b0);
    msg_bytes.push_back(8'h55);
    msg_bytes.push_back(8'hAA);
    push_word(8'h00, 1'b0, 1'b0, 1'b0);
    queue_message(1'b1, 1'b0, 1'b0);
    // random messages, mostly short so that plenty of digests come back
    while (live_words < RANDOM_WORDS + 12) begin
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(12);
      else if (pick < 92) len = $urandom_range(70, 13);
      else if (pick < 97) len = odd_len[$urandom_range(9)];
      else len = $urandom_range(200, 129);
      for (int k = 0; k < len; k++) msg_bytes.push_back(8'($urandom));
      queue_message($urandom_range(3) == 0, $urandom_range(14) == 0, 1'b1);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      msg.valid <= 1'b0;
    end else begin
      if (msg.valid && msg.ready) begin
        apply_word(cur);
        words_taken++;
      end
      if (!msg.valid || msg.ready) begin
        if (stim_q.size() != 0 && (calm() || $urandom_range(99) >= 33) &&
            !(stim_q[0].drain && digest_q.size() != 0)) begin
          cur = stim_q.pop_front();
          msg.valid <= 1'b1;
          msg.data_byte <= cur.data;
          msg.byte_valid <= cur.bval;
          msg.is_last <= cur.last;
        end else begin
          msg.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      dig.ready <= 1'b0;
    end else begin
      if (dig.valid && dig.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest with none pending: lo=%h hi=%h", $time,
                   dig.digest_lo, dig.digest_hi);
          errors++;
        end else begin
          got_want = digest_q.pop_front();
          if (dig.digest_lo !== got_want.lo) begin
            $display("%0t: digest_lo mismatch: expected %h, actual %h", $time,
                     got_want.lo, dig.digest_lo);
            errors++;
          end
          if (dig.digest_hi !== got_want.hi) begin
            $display("%0t: digest_hi mismatch: expected %h, actual %h", $time,
                     got_want.hi, dig.digest_hi);
            errors++;
          end
          digests_checked++;
        end
      end
      dig.ready <= calm() || $urandom_range(99) >= 33;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d digests outstanding", $time, digest_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    msg.valid = 1'b0;
    msg.data_byte = '0;
    msg.byte_valid = 1'b0;
    msg.is_last = 1'b0;
    dig.ready = 1'b0;
    errors = 0;
    words_taken = 0;
    digests_checked = 0;
    msgs_queued = 0;
    live_words = 0;
    cycles = 0;
    for (int k = 0; k < 16; k++) blk[k] = '0;
    start_message();
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || msg.valid || digest_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("%0d message words accepted over %0d messages, %0d digests checked",
             words_taken, msgs_queued, digests_checked);
    $display("covered empty and single-byte messages, late closes, padding spill and multi-block");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== md4_digest_engine.f =====
rtl/core/md4_pkg.sv
rtl/core/md4_if.sv
rtl/core/md4_ram.sv
rtl/core/md4_front.sv
rtl/core/md4_blkq.sv
rtl/core/md4_back.sv
rtl/core/md4_digest_engine.sv
rtl/core/md4_chk.sv
test/tb_md4_digest_engine.sv
